/* hw/rtl/complex_arithmetic_unit_macros.svh */
// assertion macros for the complex arithmetic unit
// no dependencies; expects aclk and aresetn in the including module
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/cau_pkg.sv */
// shared types for the complex arithmetic unit
// command codes, result kinds and the per-stage control struct
package cau_pkg;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_CONJ = 4'd4,
        CMD_NORM = 4'd5,
        CMD_MAG  = 4'd6,
        CMD_SCL  = 4'd7,
        CMD_DIVR = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_DIV,
        KIND_SQRT
    } res_kind_t;

    typedef struct packed {
        logic      vld;
        res_kind_t kind;
        logic      re_neg;
        logic      im_neg;
        logic      ovf_re;
        logic      ovf_im;
        logic      dz;
        logic      eq;
    } ctl_t;

endpackage

/* hw/rtl/complex_arithmetic_unit.sv */
// complex arithmetic unit top level: front end, restoring step chain, clip and output
// depends on cau_pkg, cau_front, cau_step and complex_arithmetic_unit_macros.svh
//
// Fully pipelined complex ALU on signed Q-format parts: one request per cycle while no
// stall holds the pipeline. The depth is set by the divide and magnitude paths: a chain
// of PART_WIDTH+1 restoring stages, each retiring one quotient bit of both divisions and
// one bit of the square root. Every command runs through the full depth, so results leave
// in request order. A skid register at the output keeps s_ready registered; a stall
// freezes the whole pipeline.
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit #(
    parameter int PART_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [3:0]                   s_cmd,
    input  logic signed [PART_WIDTH-1:0] s_a_re,
    input  logic signed [PART_WIDTH-1:0] s_a_im,
    input  logic signed [PART_WIDTH-1:0] s_b_re,
    input  logic signed [PART_WIDTH-1:0] s_b_im,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [PART_WIDTH-1:0] m_r_re,
    output logic signed [PART_WIDTH-1:0] m_r_im,
    output logic                         m_saturated,
    output logic                         m_div_zero,
    output logic                         m_equal
);
    import cau_pkg::*;

    localparam int W  = PART_WIDTH;
    localparam int NW = 2 * W;
    localparam int MW = 2 * W + 1;
    localparam int QW = W + 1;
    localparam int XW = 3 * W + FRAC_BITS + 1;
    localparam int NSTEP = W + 1;

    localparam logic [MW-1:0] PMAX   = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [MW-1:0] NMAX   = MW'(1) << (W - 1);
    localparam logic [W-1:0]  PMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  NMIN_W = {1'b1, {(W-1){1'b0}}};

    logic ce;

    ctl_t          ctl_c    [0:NSTEP];
    logic [NW-1:0] d_c      [0:NSTEP];
    logic [XW-1:0] rem_re_c [0:NSTEP];
    logic [XW-1:0] rem_im_c [0:NSTEP];
    logic [XW-1:0] sq_rem_c [0:NSTEP];
    logic [QW-1:0] q_re_c   [0:NSTEP];
    logic [QW-1:0] q_im_c   [0:NSTEP];
    logic [QW-1:0] root_c   [0:NSTEP];
    logic [MW-1:0] pass_re_c[0:NSTEP];
    logic [MW-1:0] pass_im_c[0:NSTEP];

    cau_front #(
        .PART_WIDTH(PART_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .s_valid  (s_valid),
        .s_cmd    (s_cmd),
        .s_a_re   (s_a_re),
        .s_a_im   (s_a_im),
        .s_b_re   (s_b_re),
        .s_b_im   (s_b_im),
        .ctl_o    (ctl_c[0]),
        .d_o      (d_c[0]),
        .rem_re_o (rem_re_c[0]),
        .rem_im_o (rem_im_c[0]),
        .sq_rem_o (sq_rem_c[0]),
        .pass_re_o(pass_re_c[0]),
        .pass_im_o(pass_im_c[0])
    );

    assign q_re_c[0] = '0;
    assign q_im_c[0] = '0;
    assign root_c[0] = '0;

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        cau_step #(
            .PART_WIDTH(PART_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .SHIFT     (W - k)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .ctl_i    (ctl_c[k]),
            .d_i      (d_c[k]),
            .rem_re_i (rem_re_c[k]),
            .rem_im_i (rem_im_c[k]),
            .sq_rem_i (sq_rem_c[k]),
            .q_re_i   (q_re_c[k]),
            .q_im_i   (q_im_c[k]),
            .root_i   (root_c[k]),
            .pass_re_i(pass_re_c[k]),
            .pass_im_i(pass_im_c[k]),
            .ctl_o    (ctl_c[k+1]),
            .d_o      (d_c[k+1]),
            .rem_re_o (rem_re_c[k+1]),
            .rem_im_o (rem_im_c[k+1]),
            .sq_rem_o (sq_rem_c[k+1]),
            .q_re_o   (q_re_c[k+1]),
            .q_im_o   (q_im_c[k+1]),
            .root_o   (root_c[k+1]),
            .pass_re_o(pass_re_c[k+1]),
            .pass_im_o(pass_im_c[k+1])
        );
    end

    // saturating conversion, returns {sat, value}
    function automatic logic [W:0] clip(input logic neg, input logic [MW-1:0] mag);
        logic [W:0] r;
        r = {1'b0, mag[W-1:0]};
        if (mag == '0) begin
            r = '0;
        end else if (!neg) begin
            if (mag > PMAX) begin
                r = {1'b1, PMAX_W};
            end
        end else if (mag > NMAX) begin
            r = {1'b1, NMIN_W};
        end else begin
            r = {1'b0, W'(-mag)};
        end
        return r;
    endfunction

    ctl_t          fc;
    logic [MW-1:0] re_mag, im_mag;
    logic [W:0]    re_clip, im_clip;
    logic [W-1:0]  res_re, res_im;
    logic          res_sat, arrive;

    always_comb begin
        fc = ctl_c[NSTEP];
        unique case (fc.kind)
            KIND_DIV: begin
                re_mag = fc.ovf_re ? '1 : MW'(q_re_c[NSTEP]);
                im_mag = fc.ovf_im ? '1 : MW'(q_im_c[NSTEP]);
            end
            KIND_SQRT: begin
                re_mag = MW'(root_c[NSTEP]);
                im_mag = pass_im_c[NSTEP];
            end
            default: begin
                re_mag = pass_re_c[NSTEP];
                im_mag = pass_im_c[NSTEP];
            end
        endcase
        re_clip = clip(fc.re_neg && fc.kind != KIND_SQRT, re_mag);
        im_clip = clip(fc.im_neg, im_mag);
        if (fc.dz) begin
            res_re  = '0;
            res_im  = '0;
            res_sat = 1'b0;
        end else begin
            res_re  = re_clip[W-1:0];
            res_im  = im_clip[W-1:0];
            res_sat = re_clip[W] | im_clip[W];
        end
        arrive = ce && fc.vld;
    end

    // output register with skid
    logic         m_valid_reg, m_valid_next;
    logic         skid_full_reg, skid_full_next;
    logic [W-1:0] out_re_reg, out_im_reg, skid_re_reg, skid_im_reg;
    logic         out_sat_reg, out_dz_reg, out_eq_reg;
    logic         skid_sat_reg, skid_dz_reg, skid_eq_reg;
    logic         out_load;

    always_comb begin
        out_load       = !m_valid_reg || m_ready;
        m_valid_next   = m_valid_reg;
        skid_full_next = skid_full_reg;
        if (out_load) begin
            m_valid_next   = skid_full_reg || arrive;
            skid_full_next = 1'b0;
        end else if (arrive) begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_re_reg  <= skid_full_reg ? skid_re_reg  : res_re;
            out_im_reg  <= skid_full_reg ? skid_im_reg  : res_im;
            out_sat_reg <= skid_full_reg ? skid_sat_reg : res_sat;
            out_dz_reg  <= skid_full_reg ? skid_dz_reg  : fc.dz;
            out_eq_reg  <= skid_full_reg ? skid_eq_reg  : fc.eq;
        end
        if (!out_load && arrive) begin
            skid_re_reg  <= res_re;
            skid_im_reg  <= res_im;
            skid_sat_reg <= res_sat;
            skid_dz_reg  <= fc.dz;
            skid_eq_reg  <= fc.eq;
        end
    end

    assign ce          = !skid_full_reg;
    assign s_ready     = ce;
    assign m_valid     = m_valid_reg;
    assign m_r_re      = out_re_reg;
    assign m_r_im      = out_im_reg;
    assign m_saturated = out_sat_reg;
    assign m_div_zero  = out_dz_reg;
    assign m_equal     = out_eq_reg;

    `CAU_ASSERT_NOW(a_dz_zero, m_valid && m_div_zero,
                    m_r_re == '0 && m_r_im == '0 && !m_saturated,
                    "zero divisor result not cleared")
    `CAU_ASSERT_NOW(a_skid_needs_out, skid_full_reg, m_valid_reg,
                    "skid holds a request while output is empty")
    `CAU_ASSERT_NEXT(a_skid_hold, skid_full_reg && !m_ready,
                     skid_full_reg && m_valid_reg,
                     "skid lost a request during stall")
    `CAU_ASSERT_NOW(a_flags_excl, m_valid, !(m_saturated && m_div_zero),
                    "saturated and div_zero both set")

endmodule

/* hw/rtl/cau_front.sv */
// front end: products, sums and divider/root setup in three register stages
// depends on cau_pkg
module cau_front #(
    parameter int PART_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ce,
    input  logic                                s_valid,
    input  logic [3:0]                          s_cmd,
    input  logic signed [PART_WIDTH-1:0]        s_a_re,
    input  logic signed [PART_WIDTH-1:0]        s_a_im,
    input  logic signed [PART_WIDTH-1:0]        s_b_re,
    input  logic signed [PART_WIDTH-1:0]        s_b_im,
    output cau_pkg::ctl_t                       ctl_o,
    output logic [2*PART_WIDTH-1:0]             d_o,
    output logic [3*PART_WIDTH+FRAC_BITS:0]     rem_re_o,
    output logic [3*PART_WIDTH+FRAC_BITS:0]     rem_im_o,
    output logic [3*PART_WIDTH+FRAC_BITS:0]     sq_rem_o,
    output logic [2*PART_WIDTH:0]               pass_re_o,
    output logic [2*PART_WIDTH:0]               pass_im_o
);
    import cau_pkg::*;

    localparam int W  = PART_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int XW = 3 * W + F + 1;

    // stage 1: products
    logic                 vld1_reg;
    cmd_t                 cmd1_reg;
    logic                 eq1_reg;
    logic signed [W-1:0]  ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [NW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [NW-1:0] p0_next, p1_next;
    logic signed [W-1:0]  m0y, m1y;
    logic                 sq_sel;

    always_comb begin
        sq_sel  = (s_cmd == CMD_NORM) || (s_cmd == CMD_MAG);
        m0y     = sq_sel ? s_a_re : s_b_re;
        m1y     = sq_sel ? s_a_im : s_b_im;
        p0_next = NW'(s_a_re) * NW'(m0y);
        p1_next = NW'(s_a_im) * NW'(m1y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cmd1_reg <= cmd_t'(s_cmd);
            eq1_reg  <= (s_a_re == s_b_re) && (s_a_im == s_b_im);
            ar1_reg  <= s_a_re;
            ai1_reg  <= s_a_im;
            br1_reg  <= s_b_re;
            bi1_reg  <= s_b_im;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= NW'(s_a_re) * NW'(s_b_im);
            p3_reg   <= NW'(s_a_im) * NW'(s_b_re);
            p4_reg   <= NW'(s_b_re) * NW'(s_b_re);
            p5_reg   <= NW'(s_b_im) * NW'(s_b_im);
        end
    end

    // stage 2: sums per command
    logic                 vld2_reg, eq2_reg, shift2_reg;
    res_kind_t            kind2_reg;
    logic signed [SW-1:0] re2_reg, im2_reg, den2_reg;
    res_kind_t            kind2_next;
    logic                 shift2_next;
    logic signed [SW-1:0] re2_next, im2_next, den2_next;

    always_comb begin
        kind2_next  = KIND_DIRECT;
        shift2_next = 1'b0;
        re2_next    = '0;
        im2_next    = '0;
        den2_next   = '0;
        unique case (cmd1_reg)
            CMD_ADD: begin
                re2_next = SW'(ar1_reg) + SW'(br1_reg);
                im2_next = SW'(ai1_reg) + SW'(bi1_reg);
            end
            CMD_SUB: begin
                re2_next = SW'(ar1_reg) - SW'(br1_reg);
                im2_next = SW'(ai1_reg) - SW'(bi1_reg);
            end
            CMD_MUL: begin
                shift2_next = 1'b1;
                re2_next    = SW'(p0_reg) - SW'(p1_reg);
                im2_next    = SW'(p2_reg) + SW'(p3_reg);
            end
            CMD_DIV: begin
                kind2_next = KIND_DIV;
                re2_next   = SW'(p0_reg) + SW'(p1_reg);
                im2_next   = SW'(p3_reg) - SW'(p2_reg);
                den2_next  = SW'(p4_reg) + SW'(p5_reg);
            end
            CMD_CONJ: begin
                re2_next = SW'(ar1_reg);
                im2_next = -SW'(ai1_reg);
            end
            CMD_NORM: begin
                shift2_next = 1'b1;
                re2_next    = SW'(p0_reg) + SW'(p1_reg);
            end
            CMD_MAG: begin
                kind2_next = KIND_SQRT;
                re2_next   = SW'(p0_reg) + SW'(p1_reg);
            end
            CMD_SCL: begin
                shift2_next = 1'b1;
                re2_next    = SW'(p0_reg);
                im2_next    = SW'(p3_reg);
            end
            CMD_DIVR: begin
                kind2_next = KIND_DIV;
                re2_next   = SW'(ar1_reg);
                im2_next   = SW'(ai1_reg);
                den2_next  = SW'(br1_reg);
            end
            default: begin
                kind2_next = KIND_DIRECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (ce) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            eq2_reg    <= eq1_reg;
            kind2_reg  <= kind2_next;
            shift2_reg <= shift2_next;
            re2_reg    <= re2_next;
            im2_reg    <= im2_next;
            den2_reg   <= den2_next;
        end
    end

    // stage 3: sign-magnitude, divider and root setup
    logic          re_neg, im_neg, den_neg, is_div;
    logic [SW-1:0] re_abs, im_abs, den_abs;
    logic [NW-1:0] d_next;
    logic [XW-1:0] rem_re_next, rem_im_next, d_top;
    ctl_t          ctl_next;

    always_comb begin
        is_div      = (kind2_reg == KIND_DIV);
        re_neg      = re2_reg[SW-1];
        im_neg      = im2_reg[SW-1];
        den_neg     = den2_reg[SW-1];
        re_abs      = re_neg ? SW'(-re2_reg) : SW'(re2_reg);
        im_abs      = im_neg ? SW'(-im2_reg) : SW'(im2_reg);
        den_abs     = den_neg ? SW'(-den2_reg) : SW'(den2_reg);
        d_next      = den_abs[NW-1:0];
        rem_re_next = XW'(re_abs[NW-1:0]) << F;
        rem_im_next = XW'(im_abs[NW-1:0]) << F;
        d_top       = XW'(d_next) << (W + 1);
        ctl_next.vld    = vld2_reg;
        ctl_next.kind   = kind2_reg;
        ctl_next.re_neg = is_div ? (re_neg ^ den_neg) : re_neg;
        ctl_next.im_neg = is_div ? (im_neg ^ den_neg) : im_neg;
        ctl_next.ovf_re = rem_re_next >= d_top;
        ctl_next.ovf_im = rem_im_next >= d_top;
        ctl_next.dz     = is_div && (den_abs == '0);
        ctl_next.eq     = eq2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o <= '0;
        end else if (ce) begin
            ctl_o <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_o       <= d_next;
            rem_re_o  <= rem_re_next;
            rem_im_o  <= rem_im_next;
            sq_rem_o  <= XW'(re_abs);
            pass_re_o <= shift2_reg ? (re_abs >> F) : re_abs;
            pass_im_o <= shift2_reg ? (im_abs >> F) : im_abs;
        end
    end

endmodule

/* hw/rtl/cau_step.sv */
// one restoring step: a quotient bit for both divisions and a root bit
// depends on cau_pkg
module cau_step #(
    parameter int PART_WIDTH = 16,
    parameter int FRAC_BITS  = 12,
    parameter int SHIFT      = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  cau_pkg::ctl_t                   ctl_i,
    input  logic [2*PART_WIDTH-1:0]         d_i,
    input  logic [3*PART_WIDTH+FRAC_BITS:0] rem_re_i,
    input  logic [3*PART_WIDTH+FRAC_BITS:0] rem_im_i,
    input  logic [3*PART_WIDTH+FRAC_BITS:0] sq_rem_i,
    input  logic [PART_WIDTH:0]             q_re_i,
    input  logic [PART_WIDTH:0]             q_im_i,
    input  logic [PART_WIDTH:0]             root_i,
    input  logic [2*PART_WIDTH:0]           pass_re_i,
    input  logic [2*PART_WIDTH:0]           pass_im_i,
    output cau_pkg::ctl_t                   ctl_o,
    output logic [2*PART_WIDTH-1:0]         d_o,
    output logic [3*PART_WIDTH+FRAC_BITS:0] rem_re_o,
    output logic [3*PART_WIDTH+FRAC_BITS:0] rem_im_o,
    output logic [3*PART_WIDTH+FRAC_BITS:0] sq_rem_o,
    output logic [PART_WIDTH:0]             q_re_o,
    output logic [PART_WIDTH:0]             q_im_o,
    output logic [PART_WIDTH:0]             root_o,
    output logic [2*PART_WIDTH:0]           pass_re_o,
    output logic [2*PART_WIDTH:0]           pass_im_o
);
    import cau_pkg::*;

    localparam int W  = PART_WIDTH;
    localparam int QW = W + 1;
    localparam int XW = 3 * W + FRAC_BITS + 1;

    logic [XW-1:0] dsh, trial;
    logic [QW-1:0] bit_q;
    logic          take_re, take_im, take_sq;

    always_comb begin
        dsh     = XW'(d_i) << SHIFT;
        trial   = (XW'(root_i) << (SHIFT + 1)) | (XW'(1) << (2 * SHIFT));
        bit_q   = QW'(1) << SHIFT;
        take_re = rem_re_i >= dsh;
        take_im = rem_im_i >= dsh;
        take_sq = sq_rem_i >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o <= '0;
        end else if (ce) begin
            ctl_o <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_o       <= d_i;
            rem_re_o  <= take_re ? (rem_re_i - dsh) : rem_re_i;
            rem_im_o  <= take_im ? (rem_im_i - dsh) : rem_im_i;
            sq_rem_o  <= take_sq ? (sq_rem_i - trial) : sq_rem_i;
            q_re_o    <= take_re ? (q_re_i | bit_q) : q_re_i;
            q_im_o    <= take_im ? (q_im_i | bit_q) : q_im_i;
            root_o    <= take_sq ? (root_i | bit_q) : root_i;
            pass_re_o <= pass_re_i;
            pass_im_o <= pass_im_i;
        end
    end

endmodule

/* bench/complex_arithmetic_unit_tb.sv */
// testbench for the complex arithmetic unit: directed and random requests with stalls
// on both channels, checked in order against a behavioral predictor of each command
// depends on cau_pkg and complex_arithmetic_unit
module complex_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int PW = 16;
    localparam int FB = 12;
    localparam longint PMAX = 32767;
    localparam longint NMAX = 32768;

    typedef struct {
        logic [3:0]           cmd;
        logic signed [PW-1:0] a_re, a_im, b_re, b_im;
        bit                   drain;
    } op_t;

    typedef struct {
        logic signed [PW-1:0] re, im;
        logic                 sat, dz, eq;
    } res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [3:0] s_cmd = '0;
    logic signed [PW-1:0] s_a_re = '0, s_a_im = '0, s_b_re = '0, s_b_im = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [PW-1:0] m_r_re, m_r_im;
    logic m_saturated, m_div_zero, m_equal;

    op_t  pending[$];
    res_t expected[$];
    int   n_sent, n_recv, n_bad, n_sat, n_dz;
    int   s_gap, m_gap;
    bit   in_reset = 1'b1;
    bit   n_sent_flag = 1'b0;
    op_t  sent_op;

    complex_arithmetic_unit #(.PART_WIDTH(PW), .FRAC_BITS(FB)) dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [PW-1:0] clip(input bit neg, input longint unsigned mag,
                                           inout logic sat);
        if (mag == 0) return '0;
        if (!neg) begin
            if (mag > PMAX) begin
                sat = 1'b1;
                return PW'(PMAX);
            end
            return PW'(mag);
        end
        if (mag > NMAX) begin
            sat = 1'b1;
            return PW'(-NMAX);
        end
        return PW'(-longint'(mag));
    endfunction

    function automatic logic [PW-1:0] clip_s(input longint v, input bit shr, inout logic sat);
        longint unsigned m;
        m = v < 0 ? -v : v;
        if (shr) m = m >> FB;
        return clip(v < 0, m, sat);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic res_t predict_result(input op_t op);
        res_t r;
        longint ar, ai, br, bi, den, num;
        longint unsigned md;
        ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
        r.re = '0; r.im = '0; r.sat = 1'b0; r.dz = 1'b0;
        r.eq = (ar == br) && (ai == bi);
        case (op.cmd)
            CMD_ADD: begin
                r.re = clip_s(ar + br, 0, r.sat);
                r.im = clip_s(ai + bi, 0, r.sat);
            end
            CMD_SUB: begin
                r.re = clip_s(ar - br, 0, r.sat);
                r.im = clip_s(ai - bi, 0, r.sat);
            end
            CMD_MUL: begin
                r.re = clip_s(ar * br - ai * bi, 1, r.sat);
                r.im = clip_s(ar * bi + ai * br, 1, r.sat);
            end
            CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num = ar * br + ai * bi;
                    md = ((num < 0 ? -num : num) << FB) / den;
                    r.re = clip(num < 0, md, r.sat);
                    num = ai * br - ar * bi;
                    md = ((num < 0 ? -num : num) << FB) / den;
                    r.im = clip(num < 0, md, r.sat);
                end
            end
            CMD_CONJ: begin
                r.re = clip_s(ar, 0, r.sat);
                r.im = clip_s(-ai, 0, r.sat);
            end
            CMD_NORM: r.re = clip_s(ar * ar + ai * ai, 1, r.sat);
            CMD_MAG: r.re = clip(0, int_sqrt(ar * ar + ai * ai), r.sat);
            CMD_SCL: begin
                r.re = clip_s(ar * br, 1, r.sat);
                r.im = clip_s(ai * br, 1, r.sat);
            end
            CMD_DIVR: begin
                if (br == 0) begin
                    r.dz = 1'b1;
                end else begin
                    den = br < 0 ? -br : br;
                    md = ((ar < 0 ? -ar : ar) << FB) / den;
                    r.re = clip((ar < 0) != (br < 0), md, r.sat);
                    md = ((ai < 0 ? -ai : ai) << FB) / den;
                    r.im = clip((ai < 0) != (br < 0), md, r.sat);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [PW-1:0] rand_part(input int style);
        case (style)
            0: return PW'($urandom);
            1: return PW'($urandom_range(0, 8191)) - 16'sd4096;
            2: case ($urandom_range(0, 4))
                   0: return 16'sh7fff;
                   1: return 16'sh8000;
                   2: return '0;
                   3: return 16'sh1000;
                   default: return -16'sh1000;
               endcase
            default: return PW'($urandom_range(0, 511)) - 16'sd256;
        endcase
    endfunction

    task automatic add_op(input logic [3:0] cmd, input logic signed [PW-1:0] ar, ai, br, bi,
                          input bit drain = 0);
        op_t op;
        op.cmd = cmd; op.a_re = ar; op.a_im = ai; op.b_re = br; op.b_im = bi;
        op.drain = drain;
        pending.push_back(op);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!in_reset && (!s_valid || n_sent_flag)) begin
            n_sent_flag = 1'b0;
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (pending.size() != 0 && !(pending[0].drain && expected.size() != 0)) begin
                s_cmd <= pending[0].cmd;
                s_a_re <= pending[0].a_re;
                s_a_im <= pending[0].a_im;
                s_b_re <= pending[0].b_re;
                s_b_im <= pending[0].b_im;
                void'(pending.pop_front());
                s_valid <= 1'b1;
                if (pending.size() > 200 && $urandom_range(0, 9) == 0)
                    s_gap <= $urandom_range(1, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (!in_reset) begin
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (pending.size() > 200 && $urandom_range(0, 9) == 0)
                    m_gap <= $urandom_range(1, 8);
            end
        end
    end

    // request acceptance and result monitor
    always @(posedge aclk) begin
        res_t e;
        if (aresetn && s_valid && s_ready) begin
            sent_op.cmd = s_cmd; sent_op.a_re = s_a_re; sent_op.a_im = s_a_im;
            sent_op.b_re = s_b_re; sent_op.b_im = s_b_im; sent_op.drain = 0;
            expected.push_back(predict_result(sent_op));
            n_sent++;
            n_sent_flag = 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            n_recv++;
            if (expected.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result re=%0d im=%0d", m_r_re, m_r_im);
            end else begin
                e = expected.pop_front();
                n_sat += e.sat;
                n_dz += e.dz;
                if (m_r_re !== e.re || m_r_im !== e.im || m_saturated !== e.sat ||
                    m_div_zero !== e.dz || m_equal !== e.eq) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("mismatch #%0d: exp re=%0d im=%0d s=%b dz=%b eq=%b",
                                 n_recv, e.re, e.im, e.sat, e.dz, e.eq);
                        $display("    got re=%0d im=%0d s=%b dz=%b eq=%b",
                                 m_r_re, m_r_im, m_saturated, m_div_zero, m_equal);
                    end
                end
            end
        end
    end

    initial begin
        int st;
        logic [3:0] c;
        logic signed [PW-1:0] ar, ai, br, bi;
        for (int k = 0; k <= 8; k++)
            add_op(4'(k), 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        add_op(CMD_ADD, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff);
        add_op(CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_op(CMD_DIV, 16'sh1000, 16'sh2000, 16'sh0000, 16'sh0000);
        add_op(CMD_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
        add_op(CMD_DIVR, 16'sh1000, 16'sh2000, 16'sh0000, 16'sh1234);
        add_op(CMD_DIVR, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh0000);
        add_op(CMD_CONJ, 16'sh1234, 16'sh8000, 16'sh0000, 16'sh0000);
        add_op(CMD_MAG, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
        add_op(CMD_MAG, 16'sh3000, 16'sh4000, 16'sh0000, 16'sh0000);
        add_op(CMD_NORM, 16'sh0001, 16'shffff, 16'sh0000, 16'sh0000);
        add_op(CMD_SCL, 16'sh2000, 16'shc000, 16'sh8000, 16'sh0000);
        add_op(4'd9, 16'sh1111, 16'sh2222, 16'sh1111, 16'sh2222);
        add_op(4'd15, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000);
        for (int n = 0; n < 1500; n++) begin
            st = $urandom_range(0, 3);
            c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
            ar = rand_part(st); ai = rand_part(st); br = rand_part(st); bi = rand_part(st);
            case ($urandom_range(0, 9))
                0: begin br = ar; bi = ai; end
                1: begin br = '0; bi = '0; end
                2: br = '0;
                default: ;
            endcase
            add_op(c, ar, ai, br, bi, n == 700);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        in_reset = 1'b0;
        wait (pending.size() == 0 && !s_valid);
        wait (expected.size() == 0);
        repeat (50) @(posedge aclk);
        $display("sent %0d requests over all nine commands and unused codes, %0d results",
                 n_sent, n_recv);
        $display("%0d results saturated, %0d divided by zero", n_sat, n_dz);
        if (n_bad == 0 && expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule
